### src/oppd_pkg.sv
// ----------------------------------------------------------------------------
// OOK pulse pair decoder package
// Widths, constants, register indexes and the sync reciprocal.
// ----------------------------------------------------------------------------
package oppd_pkg;

    localparam int DUR_W     = 20;
    localparam int DELAY_W   = 14;
    localparam int PCT_W     = 7;
    localparam int MINP_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int CODE_W    = 64;
    localparam int FIELD_W   = 8;
    localparam int ADDR_LSB  = 8;
    localparam int NET_LSB   = 16;

    localparam int SYNC_RATIO  = 71;
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP       = (2 ** RECIP_SHIFT + SYNC_RATIO - 1) / SYNC_RATIO;
    localparam int RECIP_W     = $clog2(RECIP + 1);

    localparam logic [DELAY_W-1:0] DELAY_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [PCT_W-1:0]   PCT_MAX    = PCT_W'(100);
    localparam logic [PCT_W-1:0]   PCT_RESET  = PCT_W'(60);
    localparam logic [MINP_W-1:0]  MINP_RESET = MINP_W'(15);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PAIRS,
        CFG_TOL_PCT
    } t_cfg_idx;

endpackage

### src/oppd_ifs.sv
// ----------------------------------------------------------------------------
// OOK pulse pair decoder channels
// Valid/ready interfaces for durations, results and configuration writes.
// ----------------------------------------------------------------------------
interface oppd_in_if;
    logic                        valid;
    logic                        ready;
    logic [oppd_pkg::DUR_W-1:0]  duration;
    logic                        last;

    modport source (output valid, output duration, output last, input ready);
    modport sink   (input valid, input duration, input last, output ready);
endinterface

interface oppd_out_if;
    logic                          valid;
    logic                          ready;
    logic                          valid_res;
    logic [oppd_pkg::FIELD_W-1:0]  address;
    logic [oppd_pkg::FIELD_W-1:0]  network;
    logic                          switch_state;

    modport source (output valid, output valid_res, output address, output network,
                    output switch_state, input ready);
    modport sink   (input valid, input valid_res, input address, input network,
                    input switch_state, output ready);
endinterface

interface oppd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [oppd_pkg::CFG_IDX_W-1:0]   index;
    logic [oppd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/ook_pulse_pair_decoder.sv
// ----------------------------------------------------------------------------
// OOK pulse pair decoder
// A result passes from the beat marked last through the input and result registers.
// Throughput: one duration beat per cycle, while no last beat waits on a stalled result.
// The result register decouples a stalled result from new input beats.
// Reset is synchronous, active low; it restores register defaults and the
// block then waits for a sync duration.
// ----------------------------------------------------------------------------
module ook_pulse_pair_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    oppd_in_if.sink       i_in,
    oppd_out_if.source    o_out,
    oppd_cfg_if.sink      i_cfg
);

    localparam int DIFF_W   = oppd_pkg::DUR_W + 1;
    localparam int TPROD_W  = oppd_pkg::DELAY_W + oppd_pkg::PCT_W;
    localparam int SCALED_W = DIFF_W + oppd_pkg::PCT_W;
    localparam int QPROD_W  = oppd_pkg::DUR_W + oppd_pkg::RECIP_W;

    logic [oppd_pkg::MINP_W-1:0]   r_min_pairs;
    logic [oppd_pkg::PCT_W-1:0]    r_tol_pct;

    logic                          r_in_valid;
    logic [oppd_pkg::DUR_W-1:0]    r_in_dur;
    logic                          r_in_last;

    logic                          r_awaiting, n_awaiting;
    logic [oppd_pkg::DELAY_W-1:0]  r_delay, n_delay;
    logic [oppd_pkg::PCT_W-1:0]    r_pct, n_pct;
    logic [TPROD_W-1:0]            r_prod;
    logic [oppd_pkg::DUR_W-1:0]    r_held, n_held;
    logic                          r_phase, n_phase;
    logic [oppd_pkg::CODE_W-1:0]   r_code, n_code;
    logic                          r_failed, n_failed;
    logic [oppd_pkg::COUNT_W-1:0]  r_count, n_count;

    logic                          r_out_valid;
    logic                          r_res_ok, n_res_ok;
    logic [oppd_pkg::FIELD_W-1:0]  r_address, n_address;
    logic [oppd_pkg::FIELD_W-1:0]  r_network, n_network;
    logic                          r_switch, n_switch;

    logic                          w_out_free;
    logic                          w_fire;
    logic [QPROD_W-1:0]            w_qprod;
    logic [oppd_pkg::DUR_W-1:0]    w_quot;
    logic [oppd_pkg::DELAY_W:0]    w_d2;
    logic                          w_bit0;
    logic                          w_bit1;

    // True when the value lies strictly inside center +/- floor(prod / 100).
    function automatic logic near_value(input logic [oppd_pkg::DUR_W-1:0] v,
                                        input logic [oppd_pkg::DELAY_W:0] center,
                                        input logic [TPROD_W-1:0] prod);
        logic [DIFF_W-1:0]   vx;
        logic [DIFF_W-1:0]   cx;
        logic [DIFF_W-1:0]   diff;
        logic [SCALED_W-1:0] scaled;
        vx = DIFF_W'(v);
        cx = DIFF_W'(center);
        diff = (vx >= cx) ? (vx - cx) : (cx - vx);
        scaled = (SCALED_W'(diff) + SCALED_W'(1)) * SCALED_W'(oppd_pkg::PCT_MAX);
        return scaled <= SCALED_W'(prod);
    endfunction

    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_fire      = r_in_valid && (!r_in_last || w_out_free);
    assign i_in.ready  = !r_in_valid || w_fire;
    assign i_cfg.ready = 1'b1;

    assign w_qprod = QPROD_W'(r_in_dur) * QPROD_W'(oppd_pkg::RECIP);
    assign w_quot  = oppd_pkg::DUR_W'(w_qprod >> oppd_pkg::RECIP_SHIFT);
    assign w_d2    = {r_delay, 1'b0};
    assign w_bit0  = near_value(r_held, w_d2, r_prod)
                     && near_value(r_in_dur, {1'b0, r_delay}, r_prod);
    assign w_bit1  = near_value(r_held, {1'b0, r_delay}, r_prod)
                     && near_value(r_in_dur, w_d2, r_prod);

    always_comb begin
        n_awaiting = r_awaiting;
        n_delay    = r_delay;
        n_pct      = r_pct;
        n_held     = r_held;
        n_phase    = r_phase;
        n_code     = r_code;
        n_failed   = r_failed;
        n_count    = r_count;
        n_res_ok   = 1'b0;
        n_address  = '0;
        n_network  = '0;
        n_switch   = 1'b0;
        if (w_fire) begin
            if (r_count != oppd_pkg::COUNT_MAX) begin
                n_count = r_count + oppd_pkg::COUNT_W'(1);
            end
            if (r_awaiting) begin
                n_delay    = (w_quot > oppd_pkg::DUR_W'(oppd_pkg::DELAY_MAX))
                             ? oppd_pkg::DELAY_MAX : w_quot[oppd_pkg::DELAY_W-1:0];
                n_pct      = (r_tol_pct > oppd_pkg::PCT_MAX) ? oppd_pkg::PCT_MAX : r_tol_pct;
                n_awaiting = 1'b0;
                n_phase    = 1'b0;
            end else if (!r_phase) begin
                n_held  = r_in_dur;
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                if (!r_failed) begin
                    if (w_bit0) begin
                        n_code = {r_code[oppd_pkg::CODE_W-2:1], 1'b0, 1'b0};
                    end else if (w_bit1) begin
                        n_code = {r_code[oppd_pkg::CODE_W-2:1], 1'b1, 1'b0};
                    end else begin
                        n_failed = 1'b1;
                        n_code   = '0;
                    end
                end
            end
            if (r_in_last) begin
                n_res_ok = !n_failed
                           && (n_count[oppd_pkg::COUNT_W-1:1] >= r_min_pairs)
                           && (n_code[oppd_pkg::CODE_W-1:1] != '0);
                if (n_res_ok) begin
                    n_address = n_code[oppd_pkg::ADDR_LSB+1 +: oppd_pkg::FIELD_W];
                    n_network = n_code[oppd_pkg::NET_LSB+1 +: oppd_pkg::FIELD_W];
                    n_switch  = n_code[1];
                end
                n_awaiting = 1'b1;
                n_delay    = '0;
                n_held     = '0;
                n_phase    = 1'b0;
                n_code     = '0;
                n_failed   = 1'b0;
                n_count    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pairs <= oppd_pkg::MINP_RESET;
            r_tol_pct   <= oppd_pkg::PCT_RESET;
            r_in_valid  <= 1'b0;
            r_awaiting  <= 1'b1;
            r_delay     <= '0;
            r_pct       <= '0;
            r_prod      <= '0;
            r_held      <= '0;
            r_phase     <= 1'b0;
            r_code      <= '0;
            r_failed    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (oppd_pkg::t_cfg_idx'(i_cfg.index))
                    oppd_pkg::CFG_MIN_PAIRS: r_min_pairs <= i_cfg.data[oppd_pkg::MINP_W-1:0];
                    oppd_pkg::CFG_TOL_PCT:   r_tol_pct   <= i_cfg.data[oppd_pkg::PCT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_awaiting <= n_awaiting;
            r_delay    <= n_delay;
            r_pct      <= n_pct;
            r_prod     <= TPROD_W'(r_delay) * TPROD_W'(r_pct);
            r_held     <= n_held;
            r_phase    <= n_phase;
            r_code     <= n_code;
            r_failed   <= n_failed;
            r_count    <= n_count;
            if (w_fire && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_dur  <= i_in.duration;
            r_in_last <= i_in.last;
        end
        if (w_fire && r_in_last) begin
            r_res_ok  <= n_res_ok;
            r_address <= n_address;
            r_network <= n_network;
            r_switch  <= n_switch;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.valid_res    = r_res_ok;
    assign o_out.address      = r_address;
    assign o_out.network      = r_network;
    assign o_out.switch_state = r_switch;

    a_ready_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_in_last && r_out_valid && !o_out.ready))
        else $error("input stalled without a blocked result");

    a_delay_changes_on_frame_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_delay != $past(r_delay)))
        |-> $past(w_fire && (r_awaiting || r_in_last)))
        else $error("unit delay changed outside sync or frame end");

    a_code_lsb_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_code[0])
        else $error("code accumulator low bit set");

    a_phase_not_in_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> !r_phase)
        else $error("pair phase set while waiting for sync");

    a_rejected_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res_ok)
        |-> (r_address == '0 && r_network == '0 && !r_switch))
        else $error("rejected frame carries nonzero fields");

endmodule

### verif/oppd_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK pulse pair decoder frame checker
// Watches the duration, result and configuration channels, decodes every
// accepted duration beat with its own copy of the frame state, and compares
// each result beat field by field with the oldest expected frame result.
// ----------------------------------------------------------------------------
module oppd_frame_checker
    import oppd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    oppd_in_if    in_mon,
    oppd_out_if   out_mon,
    oppd_cfg_if   cfg_mon,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic                accepted;
        logic [FIELD_W-1:0]  address;
        logic [FIELD_W-1:0]  network;
        logic                switch_state;
    } t_frame_result;

    t_frame_result        expected_frames[$];

    logic [MINP_W-1:0]    min_pairs;
    logic [PCT_W-1:0]     tol_pct;

    logic                 awaiting_sync;
    logic [DELAY_W-1:0]   unit_delay;
    logic [DELAY_W-1:0]   window_tol;
    logic [DUR_W-1:0]     held_first;
    logic                 pair_phase;
    logic [CODE_W-1:0]    code_bits;
    logic                 frame_failed;
    logic [COUNT_W-1:0]   dur_count;

    int                   n_fail = 0;

    assign o_fail_count = n_fail;

    function automatic bit near_centre(int unsigned v, int unsigned c, int unsigned t);
        return (v + t > c) && (v < c + t);
    endfunction

    task automatic clear_frame();
        awaiting_sync = 1'b1;
        unit_delay    = '0;
        window_tol    = '0;
        held_first    = '0;
        pair_phase    = 1'b0;
        code_bits     = '0;
        frame_failed  = 1'b0;
        dur_count     = '0;
    endtask

    task automatic classify_pair(int unsigned a, int unsigned b);
        int unsigned d;
        int unsigned d2;
        int unsigned t;
        d  = unit_delay;
        d2 = 2 * d;
        t  = window_tol;
        if (near_centre(a, d2, t) && near_centre(b, d, t)) begin
            code_bits = code_bits << 1;
        end else if (near_centre(a, d, t) && near_centre(b, d2, t)) begin
            code_bits = (code_bits + CODE_W'(1)) << 1;
        end else begin
            frame_failed = 1'b1;
            code_bits    = '0;
        end
    endtask

    task automatic decode_duration(logic [DUR_W-1:0] dur, logic last);
        int unsigned        d;
        int unsigned        pct;
        logic [CODE_W-1:0]  code;
        t_frame_result      res;
        if (dur_count != COUNT_MAX) begin
            dur_count = dur_count + 1'b1;
        end
        if (awaiting_sync) begin
            d = dur / SYNC_RATIO;
            if (d > DELAY_MAX) begin
                d = DELAY_MAX;
            end
            pct = (tol_pct > PCT_MAX) ? PCT_MAX : tol_pct;
            unit_delay    = DELAY_W'(d);
            window_tol    = DELAY_W'((d * pct) / int'(PCT_MAX));
            awaiting_sync = 1'b0;
            pair_phase    = 1'b0;
        end else if (!pair_phase) begin
            held_first = dur;
            pair_phase = 1'b1;
        end else begin
            pair_phase = 1'b0;
            if (!frame_failed) begin
                classify_pair(held_first, dur);
            end
        end
        if (last) begin
            code = code_bits >> 1;
            res.accepted = !frame_failed && ((dur_count / 2) >= min_pairs) && (code != '0);
            res.address      = res.accepted ? code[ADDR_LSB +: FIELD_W] : '0;
            res.network      = res.accepted ? code[NET_LSB +: FIELD_W] : '0;
            res.switch_state = res.accepted ? code[0] : 1'b0;
            expected_frames.push_back(res);
            clear_frame();
        end
    endtask

    task automatic check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $error("%s: expected %0d, actual %0d", name, exp, act);
            n_fail++;
        end
    endtask

    task automatic check_result();
        t_frame_result exp;
        if (expected_frames.size() == 0) begin
            $error("result beat with no frame result expected");
            n_fail++;
        end else begin
            exp = expected_frames.pop_front();
            check_field("valid_res", exp.accepted, out_mon.valid_res);
            check_field("address", exp.address, out_mon.address);
            check_field("network", exp.network, out_mon.network);
            check_field("switch_state", exp.switch_state, out_mon.switch_state);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_pairs = MINP_RESET;
            tol_pct   = PCT_RESET;
            clear_frame();
            expected_frames.delete();
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                check_result();
            end
            if (cfg_mon.valid && cfg_mon.ready) begin
                case (t_cfg_idx'(cfg_mon.index))
                    CFG_MIN_PAIRS: min_pairs = cfg_mon.data[MINP_W-1:0];
                    CFG_TOL_PCT:   tol_pct   = cfg_mon.data[PCT_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready) begin
                decode_duration(in_mon.duration, in_mon.last);
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OOK pulse pair decoder testbench
// Drives directed and random remote frames through the decoder under several
// register settings and handshake idling patterns, and reports the verdict
// from the frame checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
    import oppd_pkg::*;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    localparam int          LIMIT        = 200000;
    localparam int          LONG_STALL   = 400;
    localparam int          PHASE_BEATS  = 60;
    localparam int          NUM_PHASES   = 8;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          MAX_PAIRS    = 66;
    localparam int unsigned DUR_MAX      = 2 ** DUR_W - 1;
    localparam int unsigned SYNC_TOP     = DUR_MAX / SYNC_RATIO;

    logic        i_clk = 1'b0;
    logic        i_rst_n;

    oppd_in_if   in_if();
    oppd_out_if  out_if();
    oppd_cfg_if  cfg_if();

    int          fail_count;
    int          pending;
    t_idle_mode  idle_mode    = IDLE_NONE;
    int          stall_reqs   = 0;
    int          stall_served = 0;
    int          stall_left   = 0;
    int unsigned cur_min      = MINP_RESET;
    int unsigned cur_pct      = PCT_RESET;
    int          beats_sent   = 0;
    int          cycle_count  = 0;

    always #1 i_clk = ~i_clk;

    ook_pulse_pair_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    oppd_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_if),
        .out_mon      (out_if),
        .cfg_mon      (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_dur(input int unsigned dur, input bit last);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 53 : (idle_mode == IDLE_BOTH) ? 21 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid    <= 1'b1;
        in_if.duration <= DUR_W'(dur);
        in_if.last     <= last;
        do @(posedge i_clk); while (!in_if.ready);
        beats_sent++;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned min_data, input int unsigned pct_data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_MIN_PAIRS;
        cfg_if.data  <= CFG_DATA_W'(min_data);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= CFG_TOL_PCT;
        cfg_if.data  <= CFG_DATA_W'(pct_data);
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        cur_min = min_data % (2 ** MINP_W);
        cur_pct = pct_data;
    endtask

    function automatic int unsigned pick_near(int unsigned centre, int unsigned tol, bit dirty);
        int unsigned v;
        int          sel;
        sel = dirty ? $urandom_range(0, 7) : $urandom_range(3, 15);
        if (sel == 0) begin
            v = $urandom_range(0, DUR_MAX);
        end else if (sel <= 2) begin
            v = $urandom_range(0, 1) ? centre + tol : (centre >= tol ? centre - tol : 0);
        end else if (tol == 0) begin
            v = centre;
        end else if (sel == 3) begin
            v = $urandom_range(0, 1) ? centre + tol - 1 : centre - tol + 1;
        end else begin
            v = centre - (tol - 1) + $urandom_range(0, 2 * (tol - 1));
        end
        return (v > DUR_MAX) ? DUR_MAX : v;
    endfunction

    task automatic send_frame(input int pairs, input bit trailing);
        int unsigned d;
        int unsigned sync_len;
        int unsigned tol;
        int unsigned a;
        int unsigned b;
        bit          dirty;
        case ($urandom_range(0, 15))
            0:       d = SYNC_TOP;
            1:       d = $urandom_range(0, 2);
            default: d = $urandom_range(3, 400);
        endcase
        sync_len = d * SYNC_RATIO + $urandom_range(0, SYNC_RATIO - 1);
        if (sync_len > DUR_MAX) begin
            sync_len = DUR_MAX;
        end
        tol   = d * ((cur_pct > PCT_MAX) ? PCT_MAX : cur_pct) / int'(PCT_MAX);
        dirty = ($urandom_range(0, 3) == 0);
        send_dur(sync_len, (pairs == 0) && !trailing);
        for (int i = 0; i < pairs; i++) begin
            if ($urandom_range(0, 1)) begin
                a = pick_near(d, tol, dirty);
                b = pick_near(2 * d, tol, dirty);
            end else begin
                a = pick_near(2 * d, tol, dirty);
                b = pick_near(d, tol, dirty);
            end
            send_dur(a, 1'b0);
            send_dur(b, (i == pairs - 1) && !trailing);
        end
        if (trailing) begin
            send_dur($urandom_range(0, DUR_MAX), 1'b1);
        end
    endtask

    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_reqs != stall_served) begin
                stall_served++;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                case (idle_mode)
                    IDLE_RECV: out_if.ready <= ($urandom_range(0, 99) >= 53);
                    IDLE_BOTH: out_if.ready <= ($urandom_range(0, 99) >= 21);
                    default:   out_if.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ook_pulse_pair_decoder: mismatch");
        $finish;
    end

    initial begin
        int phase_start;
        int pairs;
        int lo;
        int hi;

        in_if.valid    <= 1'b0;
        in_if.duration <= '0;
        in_if.last     <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= CFG_MIN_PAIRS;
        cfg_if.data    <= '0;
        i_rst_n        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register defaults: a lone sync beat, the largest sync and an all-zero frame.
        send_dur(7100, 1'b1);
        send_dur(DUR_MAX, 1'b1);
        send_dur(0, 1'b0);
        send_dur(0, 1'b0);
        send_dur(0, 1'b1);
        drain();

        // Unit delay 100 with tolerance 60: windows are 40..160 and 140..260, open.
        set_config(1, 60);
        send_dur(7100, 1'b0);
        send_dur(200, 1'b0);
        send_dur(100, 1'b1);
        send_dur(7100, 1'b0);
        send_dur(100, 1'b0);
        send_dur(200, 1'b1);
        send_dur(7100, 1'b0);
        send_dur(300, 1'b0);
        send_dur(300, 1'b0);
        send_dur(100, 1'b0);
        send_dur(200, 1'b1);
        send_dur(7100, 1'b0);
        send_dur(100, 1'b0);
        send_dur(200, 1'b0);
        send_dur(555, 1'b1);
        send_dur(7100, 1'b0);
        send_dur(260, 1'b0);
        send_dur(100, 1'b1);
        send_dur(7100, 1'b0);
        send_dur(41, 1'b0);
        send_dur(259, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       set_config(15, 60);
                1:       set_config(0, 0);
                2:       set_config(63, 100);
                3:       set_config(7'h41, 127);
                4:       set_config(0, 101);
                default: set_config($urandom_range(0, 10), $urandom_range(20, 100));
            endcase
            idle_mode = t_idle_mode'(p % 4);
            if (p == 5) begin
                stall_reqs++;
            end
            phase_start = beats_sent;
            while (beats_sent < phase_start + PHASE_BEATS) begin
                lo = (cur_min > 2) ? cur_min - 2 : 1;
                hi = (cur_min + 6 > MAX_PAIRS) ? MAX_PAIRS : cur_min + 6;
                pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(lo, hi);
                send_frame(pairs, $urandom_range(0, 3) == 0);
            end
            drain();
        end

        idle_mode = IDLE_NONE;
        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("ook_pulse_pair_decoder: match");
        end else begin
            $display("ook_pulse_pair_decoder: mismatch");
        end
        $finish;
    end

endmodule
